### rtl/core/cma_pkg.sv
// ----------------------------------------------------------------------------
// cma_pkg
// shared constants and the spin decode function of the covariance matrix accumulator
// ----------------------------------------------------------------------------
`default_nettype none
package cma_pkg;
  localparam int SITES = 16;
  localparam int MAX_SAMPLES = 65535;
  localparam int SITE_W = $clog2(SITES);
  localparam int SUM_W = 18;
  localparam int CNT_W = 16;
  localparam int COV_W = 18;
  localparam int PROD_W = 36;
  localparam int NUM_W = 50;
  localparam int DEN_W = 32;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic signed [COV_W-1:0] COV_MAX = 18'sd131071;
  localparam logic signed [COV_W-1:0] COV_MIN = -18'sd131072;

  function automatic logic signed [1:0] spin_of(input logic [1:0] b);
    logic signed [1:0] s;
    case (b)
      2'b01: s = 2'sd1;
      2'b11: s = -2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction
endpackage
`default_nettype wire

### rtl/core/cma_lane.sv
// ----------------------------------------------------------------------------
// cma_lane
// one site lane: holds column sums of pair products and the site sum
// ----------------------------------------------------------------------------
`default_nettype none
module cma_lane (
  input  wire logic clk,
  input  wire logic clr,
  input  wire logic upd,
  input  wire logic [cma_pkg::SITE_W-1:0] row,
  input  wire logic signed [1:0] row_spin,
  input  wire logic signed [1:0] own_spin,
  input  wire logic site_upd,
  input  wire logic [cma_pkg::SITE_W-1:0] rd_row,
  output logic signed [cma_pkg::SUM_W-1:0] pair_q,
  output logic signed [cma_pkg::SUM_W-1:0] site_q
);
  logic signed [cma_pkg::SUM_W-1:0] col_sums [cma_pkg::SITES];
  logic signed [cma_pkg::SUM_W-1:0] prod;

  assign prod = cma_pkg::SUM_W'(row_spin * own_spin);

  always_ff @(posedge clk) begin
    if (clr) begin
      for (int i = 0; i < cma_pkg::SITES; i++) col_sums[i] <= '0;
      site_q <= '0;
    end else begin
      if (upd) col_sums[row] <= col_sums[row] + prod;
      if (site_upd) site_q <= site_q + cma_pkg::SUM_W'(own_spin);
    end
    pair_q <= col_sums[rd_row];
  end
endmodule
`default_nettype wire

### rtl/core/cma_div.sv
// ----------------------------------------------------------------------------
// cma_div
// signed restoring divider, one quotient bit per cycle, truncating, saturating to COV_W
// ----------------------------------------------------------------------------
`default_nettype none
module cma_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic go,
  input  wire logic signed [cma_pkg::NUM_W-1:0] num,
  input  wire logic [cma_pkg::DEN_W-1:0] den,
  output logic done,
  output logic signed [cma_pkg::COV_W-1:0] quo
);
  localparam int CW = $clog2(cma_pkg::NUM_W + 1);
  localparam int SQ_W = cma_pkg::NUM_W + 1;
  logic [cma_pkg::NUM_W-1:0] q, mag;
  logic [cma_pkg::DEN_W:0] rem, trial;
  logic [cma_pkg::DEN_W-1:0] d;
  logic neg, run;
  logic [CW-1:0] cnt;
  logic signed [SQ_W-1:0] sq;

  assign trial = {rem[cma_pkg::DEN_W-1:0], mag[cma_pkg::NUM_W-1]} - {1'b0, d};
  assign sq = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    done <= !rst && !go && run && (cnt == '0);
    if (rst) begin
      run <= 1'b0;
    end else if (go) begin
      run <= 1'b1;
      neg <= num[cma_pkg::NUM_W-1];
      mag <= num[cma_pkg::NUM_W-1] ? cma_pkg::NUM_W'(-num) : num;
      d <= den;
      rem <= '0;
      q <= '0;
      cnt <= CW'(cma_pkg::NUM_W);
    end else if (run) begin
      if (cnt == '0) begin
        run <= 1'b0;
        if (sq > SQ_W'(cma_pkg::COV_MAX)) quo <= cma_pkg::COV_MAX;
        else if (sq < SQ_W'(cma_pkg::COV_MIN)) quo <= cma_pkg::COV_MIN;
        else quo <= sq[cma_pkg::COV_W-1:0];
      end else begin
        cnt <= cnt - 1'b1;
        mag <= mag << 1;
        if (!trial[cma_pkg::DEN_W]) begin
          rem <= trial;
          q <= {q[cma_pkg::NUM_W-2:0], 1'b1};
        end else begin
          rem <= {rem[cma_pkg::DEN_W-1:0], mag[cma_pkg::NUM_W-1]};
          q <= {q[cma_pkg::NUM_W-2:0], 1'b0};
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/core/covariance_matrix_accumulator_unit.sv
// ----------------------------------------------------------------------------
// covariance_matrix_accumulator_unit
// sample covariance matrix accumulator over 16 spin sites
// ----------------------------------------------------------------------------
// An add steps through the sixteen rows, one row of pair sums per cycle; the
// lanes at or above that row update it, and the site sums update on row zero.
// A read runs lane read, multiply and combine steps and then the bit-serial
// divider (one quotient bit per cycle over a 50-bit numerator). A clear or
// refused add goes straight to the result state. Start is taken only while
// busy is low; the result strobe lasts one cycle and cannot be held off.
`default_nettype none
module covariance_matrix_accumulator_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire logic [1:0] operation,
  input  wire logic [31:0] spin_word,
  input  wire logic [3:0] row_site,
  input  wire logic [3:0] col_site,
  output logic done,
  output logic signed [17:0] cov_value,
  output logic [1:0] status,
  output logic [15:0] samples_held
);
  localparam int SW = cma_pkg::SITE_W;
  typedef enum logic [2:0] {S_IDLE, S_ADD, S_RD0, S_RD1, S_RD2, S_DIV, S_OUT} state_t;
  state_t state;
  logic [31:0] word;
  logic [SW-1:0] r, c, row;
  logic [cma_pkg::CNT_W-1:0] count;
  logic clr, upd;
  logic signed [1:0] spins [cma_pkg::SITES];
  logic signed [cma_pkg::SUM_W-1:0] pq [cma_pkg::SITES];
  logic signed [cma_pkg::SUM_W-1:0] sq [cma_pkg::SITES];
  logic signed [cma_pkg::SUM_W-1:0] sr, sc;
  logic signed [cma_pkg::PROD_W-1:0] mp, ss;
  logic signed [cma_pkg::NUM_W-1:0] num;
  logic [cma_pkg::DEN_W-1:0] den;
  logic div_go, div_done;
  logic signed [cma_pkg::COV_W-1:0] quo;

  assign clr = rst || (state == S_IDLE && start && operation == cma_pkg::OP_CLEAR);
  assign upd = state == S_ADD;

  for (genvar i = 0; i < cma_pkg::SITES; i++) begin : g_lane
    assign spins[i] = cma_pkg::spin_of(word[2*i+1:2*i]);
    cma_lane u_lane (
      .clk(clk), .clr(clr), .upd(upd && (SW'(i) >= row)), .row(row),
      .row_spin(spins[row]), .own_spin(spins[i]),
      .site_upd(upd && row == '0), .rd_row(r),
      .pair_q(pq[i]), .site_q(sq[i])
    );
  end

  cma_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(num), .den(den),
    .done(div_done), .quo(quo)
  );

  assign samples_held = count;

  always_ff @(posedge clk) begin
    done <= !rst && (state == S_OUT);
    div_go <= !rst && (state == S_RD2);
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            word <= spin_word;
            r <= (col_site < row_site) ? col_site : row_site;
            c <= (col_site < row_site) ? row_site : col_site;
            cov_value <= '0;
            status <= cma_pkg::ST_OK;
            case (operation)
              cma_pkg::OP_ADD: begin
                if (32'(count) >= 32'(cma_pkg::MAX_SAMPLES)) begin
                  status <= cma_pkg::ST_FULL;
                  state <= S_OUT;
                end else begin
                  row <= '0;
                  state <= S_ADD;
                end
                busy <= 1'b1;
              end
              cma_pkg::OP_READ: begin
                busy <= 1'b1;
                if (count == '0) begin
                  status <= cma_pkg::ST_EMPTY;
                  state <= S_OUT;
                end else state <= S_RD0;
              end
              cma_pkg::OP_CLEAR: begin
                count <= '0;
                busy <= 1'b1;
                state <= S_OUT;
              end
              default: begin
                busy <= 1'b1;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_ADD: begin
          row <= row + 1'b1;
          if (row == SW'(cma_pkg::SITES - 1)) begin
            count <= count + 1'b1;
            state <= S_OUT;
          end
        end
        S_RD0: begin
          sr <= sq[r];
          sc <= sq[c];
          state <= S_RD1;
        end
        S_RD1: begin
          mp <= cma_pkg::PROD_W'($signed({1'b0, count})) * cma_pkg::PROD_W'(pq[c]);
          ss <= cma_pkg::PROD_W'(sr) * cma_pkg::PROD_W'(sc);
          den <= cma_pkg::DEN_W'(count) * cma_pkg::DEN_W'(count);
          state <= S_RD2;
        end
        S_RD2: begin
          num <= cma_pkg::NUM_W'(mp - ss) <<< 16;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            cov_value <= quo;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### verif/covariance_matrix_accumulator_unit_tb.sv
// ----------------------------------------------------------------------------
// covariance_matrix_accumulator_unit_tb
// Drives add, read, clear and unused operation words into the accumulator
// with random gaps, predicts every result from an internal copy of the pair
// sums, site sums and sample count, and checks each strobed result in order.
// ----------------------------------------------------------------------------
module covariance_matrix_accumulator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] word;
    logic [3:0]  row;
    logic [3:0]  col;
    int          gap;
  } cmd_t;

  typedef struct {
    logic signed [17:0] cov;
    logic [1:0]         st;
    logic [15:0]        held;
  } res_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic [1:0] operation = cma_pkg::OP_ADD;
  logic [31:0] spin_word = '0;
  logic [3:0] row_site = '0;
  logic [3:0] col_site = '0;
  logic busy, done;
  logic signed [17:0] cov_value;
  logic [1:0] status;
  logic [15:0] samples_held;

  covariance_matrix_accumulator_unit DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .spin_word(spin_word), .row_site(row_site), .col_site(col_site),
    .done(done), .cov_value(cov_value), .status(status), .samples_held(samples_held)
  );

  cmd_t pending_words[$];
  res_t expected_results[$];
  longint pair_acc[16][16];
  longint site_acc[16];
  longint count_acc;
  int errors = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit taken = 0;

  initial forever #6 clk = ~clk;

  function automatic int site_spin(logic [31:0] w, int i);
    case (w[2*i +: 2])
      2'b01: return 1;
      2'b11: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic void clear_sums();
    for (int r = 0; r < 16; r++) begin
      site_acc[r] = 0;
      for (int c = 0; c < 16; c++) pair_acc[r][c] = 0;
    end
    count_acc = 0;
  endfunction

  function automatic res_t covariance_of(cmd_t w);
    res_t x;
    int s[16];
    int r, c;
    longint num, v;
    x.cov = 0;
    x.st = cma_pkg::ST_OK;
    if (w.op == cma_pkg::OP_ADD) begin
      if (count_acc >= cma_pkg::MAX_SAMPLES) x.st = cma_pkg::ST_FULL;
      else begin
        for (int i = 0; i < 16; i++) begin
          s[i] = site_spin(w.word, i);
          site_acc[i] += s[i];
        end
        for (int i = 0; i < 16; i++)
          for (int j = i; j < 16; j++) pair_acc[i][j] += s[i] * s[j];
        count_acc++;
      end
    end else if (w.op == cma_pkg::OP_READ) begin
      if (count_acc == 0) x.st = cma_pkg::ST_EMPTY;
      else begin
        r = (w.col < w.row) ? w.col : w.row;
        c = (w.col < w.row) ? w.row : w.col;
        num = count_acc * pair_acc[r][c] - site_acc[r] * site_acc[c];
        v = (num * 65536) / (count_acc * count_acc);
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        x.cov = v[17:0];
      end
    end else if (w.op == cma_pkg::OP_CLEAR) begin
      clear_sums();
    end
    x.held = count_acc[15:0];
    return x;
  endfunction

  function automatic logic [31:0] rand_spins();
    logic [31:0] w;
    if ($urandom_range(0, 3) == 0) return $urandom;
    for (int i = 0; i < 16; i++) begin
      case ($urandom_range(0, 2))
        0: w[2*i +: 2] = 2'b01;
        1: w[2*i +: 2] = 2'b11;
        default: w[2*i +: 2] = 2'b00;
      endcase
    end
    return w;
  endfunction

  task automatic push_word(logic [1:0] op, logic [31:0] w, logic [3:0] r, logic [3:0] c,
                           int g);
    cmd_t x;
    x.op = op; x.word = w; x.row = r; x.col = c; x.gap = g;
    pending_words.push_back(x);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst && (!start || taken)) begin
      taken = 0;
      if (gap_left > 0) begin
        gap_left--;
        start <= 0;
      end else if (pending_words.size() > 0) begin
        cmd_t x;
        x = pending_words.pop_front();
        operation <= x.op;
        spin_word <= x.word;
        row_site <= x.row;
        col_site <= x.col;
        start <= 1;
        gap_left = (pending_words.size() > 0) ? pending_words[0].gap : 0;
      end else start <= 0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (done) begin
        idle_cycles = 0;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result cov %0d status %0d held %0d",
                   $time, cov_value, status, samples_held);
          errors++;
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (cov_value !== e.cov) begin
            $display("%0t: cov_value expected %0d actual %0d", $time, e.cov, cov_value);
            errors++;
          end
          if (status !== e.st) begin
            $display("%0t: status expected %0d actual %0d", $time, e.st, status);
            errors++;
          end
          if (samples_held !== e.held) begin
            $display("%0t: samples_held expected %0d actual %0d", $time, e.held,
                     samples_held);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        cmd_t x;
        idle_cycles = 0;
        x.op = operation; x.word = spin_word; x.row = row_site; x.col = col_site;
        expected_results.push_back(covariance_of(x));
        taken = 1;
      end
      if (idle_cycles >= 3000) begin
        $display("covariance_matrix_accumulator_unit_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int quiet;
    int g;
    logic [1:0] op;
    clear_sums();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed
    push_word(cma_pkg::OP_READ, '0, 4'd0, 4'd0, 0);
    push_word(cma_pkg::OP_ADD, 32'h5555_5555, 4'd0, 4'd0, 0);
    push_word(cma_pkg::OP_READ, '0, 4'd0, 4'd15, 3);
    push_word(cma_pkg::OP_ADD, 32'hFFFF_FFFF, 4'd0, 4'd0, 0);
    push_word(cma_pkg::OP_READ, '0, 4'd15, 4'd0, 0);
    push_word(cma_pkg::OP_READ, '0, 4'd7, 4'd7, 13);
    push_word(cma_pkg::OP_ADD, 32'hAAAA_AAAA, 4'd0, 4'd0, 1);
    push_word(cma_pkg::OP_ADD, 32'h0000_0000, 4'd0, 4'd0, 0);
    push_word(cma_pkg::OP_ADD, 32'h3333_3333, 4'd0, 4'd0, 0);
    push_word(cma_pkg::OP_ADD, 32'hC5C5_1D1D, 4'd0, 4'd0, 0);
    push_word(cma_pkg::OP_READ, '0, 4'd0, 4'd0, 0);
    push_word(cma_pkg::OP_READ, '0, 4'd15, 4'd15, 0);
    push_word(cma_pkg::OP_READ, '0, 4'd3, 4'd9, 2);
    push_word(cma_pkg::OP_READ, '0, 4'd9, 4'd3, 0);
    push_word(cma_pkg::OP_UNUSED, 32'hFFFF_FFFF, 4'd15, 4'd15, 0);
    push_word(cma_pkg::OP_CLEAR, '0, 4'd0, 4'd0, 0);
    push_word(cma_pkg::OP_READ, '0, 4'd1, 4'd2, 0);
    push_word(cma_pkg::OP_ADD, 32'h0000_0001, 4'd0, 4'd0, 0);
    push_word(cma_pkg::OP_READ, '0, 4'd0, 4'd0, 0);

    // random
    quiet = 0;
    for (int n = 0; n < 1520; n++) begin
      if (n % 100 == 0) quiet = $urandom_range(0, 2) == 0;
      g = quiet ? 0 : $urandom_range(0, 13);
      case ($urandom_range(0, 19))
        0: op = cma_pkg::OP_CLEAR;
        1: op = cma_pkg::OP_UNUSED;
        2, 3, 4, 5, 6, 7, 8, 9: op = cma_pkg::OP_READ;
        default: op = cma_pkg::OP_ADD;
      endcase
      push_word(op, (op == cma_pkg::OP_ADD) ? rand_spins() : $urandom, 4'($urandom),
                4'($urandom), g);
    end

    push_word(cma_pkg::OP_READ, '0, 4'd0, 4'd15, 0);
    push_word(cma_pkg::OP_READ, '0, 4'd4, 4'd4, 0);
    push_word(cma_pkg::OP_CLEAR, '0, 4'd0, 4'd0, 0);
    push_word(cma_pkg::OP_ADD, 32'hFFFF_FFFF, 4'd0, 4'd0, 0);

    wait (pending_words.size() == 0 && !start && expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("covariance_matrix_accumulator_unit_tb: clean");
    else
      $display("covariance_matrix_accumulator_unit_tb: errors");
    $finish;
  end
endmodule
